/* src/tsu_pkg.sv */
// tsu_pkg: shared constants and types for the taylor series sine unit
// used by tsu_mul, taylor_sine_unit, tsu_checker and the bench, no dependencies
package tsu_pkg;

  // fixed-point formats
  localparam int ANGLE_FRAC_BITS = 24;
  localparam int INT_FRAC        = 40;
  localparam int OUT_FRAC        = 30;
  localparam int OUT_SHIFT       = INT_FRAC - OUT_FRAC;

  // range reduction: |angle| moved to 40 fraction bits
  localparam int RED_SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int RED_W     = 32 + RED_SHIFT;
  localparam int MOD_W     = 43;
  localparam int RED_STEPS = RED_W - MOD_W;
  localparam int RED_KW    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic [MOD_W-1:0] TWO_PI_Q40 = 43'd6908429469410;

  // magnitudes and multiplier
  localparam int MAG_W  = 47;
  localparam int OP_W   = 48;
  localparam int HALF_W = OP_W / 2;
  localparam int PROD_W = 2 * OP_W;
  localparam int TOLP_W = MAG_W + 32;

  // divider
  localparam int D_W       = 22;
  localparam int DIV_STEPS = OP_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // configuration
  localparam int N_W       = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
  localparam logic [31:0]    TOL_RESET   = 32'd429497;
  localparam logic [N_W-1:0] LIMIT_CAP   = 10'd1000;

  // partial product placement inside the multiplier
  typedef enum logic [1:0] {
    PP_LL = 2'd0,
    PP_HL = 2'd1,
    PP_LH = 2'd2,
    PP_HH = 2'd3
  } pp_sel_e;

endpackage

/* src/tsu_mul.sv */
// tsu_mul: 48x48 unsigned multiplier built from four 24x24 partial products
// depends on tsu_pkg; operands must stay stable until done_o
module tsu_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsu_pkg::OP_W-1:0]    a_i,
  input  logic [tsu_pkg::OP_W-1:0]    b_i,
  output logic                        done_o,
  output logic [tsu_pkg::PROD_W-1:0]  prod_o
);
  import tsu_pkg::*;

  logic                run_q, pv_q, done_q;
  pp_sel_e             cnt_q, sh_q;
  logic [OP_W-1:0]     pp_q;
  logic [PROD_W-1:0]   acc_q, pp_shifted;
  logic [HALF_W-1:0]   a_part, b_part;

  // operand halves for the current partial product
  always_comb begin
    case (cnt_q)
      PP_LL: begin a_part = a_i[HALF_W-1:0];    b_part = b_i[HALF_W-1:0]; end
      PP_HL: begin a_part = a_i[OP_W-1:HALF_W]; b_part = b_i[HALF_W-1:0]; end
      PP_LH: begin a_part = a_i[HALF_W-1:0];    b_part = b_i[OP_W-1:HALF_W]; end
      PP_HH: begin a_part = a_i[OP_W-1:HALF_W]; b_part = b_i[OP_W-1:HALF_W]; end
      default: begin a_part = '0; b_part = '0; end
    endcase
  end

  // align the registered partial product
  always_comb begin
    case (sh_q)
      PP_LL:        pp_shifted = {{OP_W{1'b0}}, pp_q};
      PP_HL, PP_LH: pp_shifted = {{OP_W{1'b0}}, pp_q} << HALF_W;
      PP_HH:        pp_shifted = {{OP_W{1'b0}}, pp_q} << OP_W;
      default:      pp_shifted = '0;
    endcase
  end

  // sequencing of partial products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= PP_LL;
      sh_q   <= PP_LL;
    end else if (start_i) begin
      run_q  <= 1'b1;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= PP_LL;
    end else begin
      pv_q   <= run_q;
      done_q <= pv_q && (sh_q == PP_HH);
      if (run_q) begin
        sh_q  <= cnt_q;
        cnt_q <= pp_sel_e'(cnt_q + 2'd1);
        if (cnt_q == PP_HH) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (run_q) begin
      pp_q <= a_part * b_part;
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + pp_shifted;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* src/taylor_sine_unit.sv */
// taylor_sine_unit: sine of a Q8.24 angle by Taylor series on one shared multiplier
// depends on tsu_pkg and tsu_mul
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+-------------------------
//  command   | start_i, busy_o, angle_i                      | taken when start_i & !busy_o
//  result    | done_o, sine_value_o, terms_used_o, gave_up_o | done_o high one cycle
//  config    | cfg_valid_i, cfg_ready_o, cfg_index_i,        | taken when valid & ready
//            | cfg_wdata_i                                   |
//
// one angle runs from acceptance to its result through range reduction, one quotient
// bit per step, a squaring multiply, then per term a multiply, the radix-4 divider,
// the sum update and magnitude states, a tolerance multiply and a test state.
// the 4-pass 24x24 multiplier and the divider set the run time.
// busy_o stays high from acceptance until the cycle of done_o; the receiver
// cannot stall, so a result is never held. reset restores the default registers.
module taylor_sine_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic signed [31:0]             angle_i,
  output logic                           done_o,
  output logic signed [31:0]             sine_value_o,
  output logic [tsu_pkg::N_W-1:0]        terms_used_o,
  output logic                           gave_up_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_wdata_i
);
  import tsu_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RED  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_ABS  = 7'b0100000,
    S_CHK  = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    M_SQ   = 2'd0,
    M_TERM = 2'd1,
    M_TOL  = 2'd2
  } mul_sel_e;

  localparam logic signed [48:0] SUM_HI = {2'b00, {MAG_W{1'b1}}};
  localparam logic signed [48:0] SUM_LO = -SUM_HI;
  localparam int Q_W = MAG_W - OUT_SHIFT;
  localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'(32'h7FFF_FFFF);
  localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(32'h8000_0000);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIV_STEPS - 1);

  // product to Q.40, truncated, saturated
  function automatic logic [MAG_W-1:0] sat40(input logic [PROD_W-1:0] p);
    logic [MAG_W-1:0] r;
    if (|p[PROD_W-1:INT_FRAC+MAG_W]) begin
      r = {MAG_W{1'b1}};
    end else begin
      r = p[INT_FRAC+MAG_W-1:INT_FRAC];
    end
    return r;
  endfunction

  state_e                  state_q;
  mul_sel_e                mul_sel_q;
  logic                    mul_go_q;
  logic [RED_KW-1:0]       k_q;
  logic [DCNT_W-1:0]       dcnt_q;
  logic [N_W-1:0]          n_q, limit_q;
  logic [31:0]             tol_q;
  logic                    done_q;

  logic [RED_W-1:0]        red_q;
  logic                    neg_q;
  logic                    t_neg_q;
  logic [MAG_W-1:0]        t_mag_q, xsq_q, smag_q;
  logic signed [OP_W-1:0]  sum_q;
  logic [D_W-1:0]          d_q;
  logic [OP_W-1:0]         num_q;
  logic [D_W-1:0]          rem_q;
  logic [TOLP_W-1:0]       tolprod_q;
  logic signed [31:0]      sine_q;
  logic [N_W-1:0]          terms_q;
  logic                    gave_q;

  logic                    accept;
  logic [31:0]             angle_u, mag32;
  logic [RED_W-1:0]        mod_sh, red_next;
  logic [MOD_W-1:0]        mag_red;
  logic [OP_W-1:0]         mul_a, mul_b;
  logic                    mul_done;
  logic [PROD_W-1:0]       mul_prod;
  logic [D_W:0]            t1, t2;
  logic                    ge1, ge2;
  logic [D_W-1:0]          r1, r2;
  logic [MAG_W-1:0]        quot;
  logic                    new_tneg;
  logic signed [48:0]      p_ext, s_wide, s_clamp;
  logic [OP_W-1:0]         sum_neg;
  logic                    sum_zero, converged, over_limit, finish;
  logic [Q_W-1:0]          q_out;
  logic signed [31:0]      sine_d;
  logic [N_W-1:0]          limit_wr;

  assign accept      = (state_q == S_IDLE) && start_i;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // angle magnitude and reduction step
  always_comb begin
    angle_u  = angle_i;
    mag32    = angle_i[31] ? (~angle_u + 32'd1) : angle_u;
    mod_sh   = {{(RED_W-MOD_W){1'b0}}, TWO_PI_Q40} << k_q;
    red_next = (red_q >= mod_sh) ? (red_q - mod_sh) : red_q;
    mag_red  = red_next[MOD_W-1:0];
  end

  // shared multiplier operand selection
  always_comb begin
    case (mul_sel_q)
      M_SQ:    begin mul_a = {1'b0, t_mag_q}; mul_b = {1'b0, t_mag_q}; end
      M_TERM:  begin mul_a = {1'b0, t_mag_q}; mul_b = {1'b0, xsq_q}; end
      M_TOL:   begin mul_a = {1'b0, smag_q};  mul_b = {{(OP_W-32){1'b0}}, tol_q}; end
      default: begin mul_a = '0;              mul_b = '0; end
    endcase
  end

  tsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go_q),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // two restoring division steps per cycle
  always_comb begin
    t1  = {rem_q, num_q[OP_W-1]};
    ge1 = (t1 >= {1'b0, d_q});
    r1  = ge1 ? D_W'(t1 - {1'b0, d_q}) : t1[D_W-1:0];
    t2  = {r1, num_q[OP_W-2]};
    ge2 = (t2 >= {1'b0, d_q});
    r2  = ge2 ? D_W'(t2 - {1'b0, d_q}) : t2[D_W-1:0];
  end

  // next term and clamped sum
  always_comb begin
    quot     = num_q[MAG_W-1:0];
    new_tneg = !t_neg_q && (t_mag_q != '0);
    p_ext    = {2'b00, quot};
    s_wide   = new_tneg ? ({sum_q[OP_W-1], sum_q} - p_ext) : ({sum_q[OP_W-1], sum_q} + p_ext);
    if (s_wide > SUM_HI) begin
      s_clamp = SUM_HI;
    end else if (s_wide < SUM_LO) begin
      s_clamp = SUM_LO;
    end else begin
      s_clamp = s_wide;
    end
    sum_neg = -sum_q;
  end

  // stop tests and output value
  always_comb begin
    sum_zero   = (sum_q == '0);
    converged  = ({t_mag_q, 32'd0} <= tolprod_q);
    over_limit = (n_q > limit_q);
    finish     = sum_zero || converged || over_limit;
    q_out      = smag_q[MAG_W-1:OUT_SHIFT];
    if (!sum_zero && !converged) begin
      sine_d = '0;
    end else if (sum_q[OP_W-1]) begin
      sine_d = -$signed((q_out > Q_NEG_MAX) ? Q_NEG_MAX[31:0] : q_out[31:0]);
    end else begin
      sine_d = $signed((q_out > Q_POS_MAX) ? Q_POS_MAX[31:0] : q_out[31:0]);
    end
  end

  assign limit_wr = (cfg_wdata_i[N_W-1:0] > LIMIT_CAP) ? LIMIT_CAP : cfg_wdata_i[N_W-1:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= TOL_RESET;
      limit_q <= LIMIT_CAP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TOL:   tol_q   <= cfg_wdata_i;
        REG_LIMIT: limit_q <= limit_wr;
        default:   ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mul_sel_q <= M_SQ;
      mul_go_q  <= 1'b0;
      k_q       <= '0;
      dcnt_q    <= '0;
      n_q       <= '0;
      done_q    <= 1'b0;
    end else begin
      mul_go_q <= 1'b0;
      done_q   <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            k_q     <= RED_KW'(RED_STEPS - 1);
            state_q <= S_RED;
          end
        end
        S_RED: begin
          if (k_q == '0) begin
            n_q       <= N_W'(1);
            mul_sel_q <= M_SQ;
            mul_go_q  <= 1'b1;
            state_q   <= S_MUL;
          end else begin
            k_q <= k_q - RED_KW'(1);
          end
        end
        S_MUL: begin
          if (mul_done) begin
            case (mul_sel_q)
              M_SQ: begin
                mul_sel_q <= M_TERM;
                mul_go_q  <= 1'b1;
              end
              M_TERM: begin
                dcnt_q  <= '0;
                state_q <= S_DIV;
              end
              M_TOL:   state_q <= S_CHK;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (dcnt_q == DCNT_LAST) begin
            state_q <= S_SUM;
          end else begin
            dcnt_q <= dcnt_q + DCNT_W'(1);
          end
        end
        S_SUM: begin
          n_q     <= n_q + N_W'(1);
          state_q <= S_ABS;
        end
        S_ABS: begin
          mul_sel_q <= M_TOL;
          mul_go_q  <= 1'b1;
          state_q   <= S_MUL;
        end
        S_CHK: begin
          if (finish) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            mul_sel_q <= M_TERM;
            mul_go_q  <= 1'b1;
            state_q   <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          neg_q <= angle_i[31];
          red_q <= {{(RED_W-32){1'b0}}, mag32} << RED_SHIFT;
        end
      end
      S_RED: begin
        red_q <= red_next;
        if (k_q == '0) begin
          t_mag_q <= {{(MAG_W-MOD_W){1'b0}}, mag_red};
          t_neg_q <= neg_q;
          sum_q   <= neg_q ? -$signed({{(OP_W-MOD_W){1'b0}}, mag_red})
                           :  $signed({{(OP_W-MOD_W){1'b0}}, mag_red});
          d_q     <= D_W'(6);
        end
      end
      S_MUL: begin
        if (mul_done) begin
          case (mul_sel_q)
            M_SQ:    xsq_q     <= sat40(mul_prod);
            M_TERM: begin
              num_q <= {1'b0, sat40(mul_prod)};
              rem_q <= '0;
            end
            M_TOL:   tolprod_q <= mul_prod[TOLP_W-1:0];
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rem_q <= r2;
        num_q <= {num_q[OP_W-3:0], ge1, ge2};
      end
      S_SUM: begin
        t_mag_q <= quot;
        t_neg_q <= new_tneg;
        sum_q   <= s_clamp[OP_W-1:0];
        d_q     <= d_q + D_W'({n_q, 3'b000}) + D_W'(6);
      end
      S_ABS: begin
        smag_q <= sum_q[OP_W-1] ? sum_neg[MAG_W-1:0] : sum_q[MAG_W-1:0];
      end
      S_CHK: begin
        if (finish) begin
          sine_q  <= sine_d;
          terms_q <= n_q;
          gave_q  <= !sum_zero && !converged;
        end
      end
      default: ;
    endcase
  end

  assign done_o       = done_q;
  assign sine_value_o = sine_q;
  assign terms_used_o = terms_q;
  assign gave_up_o    = gave_q;

endmodule

/* src/tsu_checker.sv */
// tsu_checker: port-level assertions for taylor_sine_unit
// depends on tsu_pkg; bound to the top level at the end of this file
module tsu_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic signed [31:0]       sine_value_o,
  input logic [tsu_pkg::N_W-1:0]  terms_used_o,
  input logic                     gave_up_o
);
  import tsu_pkg::*;

  // an accepted transaction makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("unit not busy after accepting a transaction");

  // leaving busy always delivers a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // one result per transaction, never two in a row
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // give-up returns zero
  a_gave_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && gave_up_o |-> sine_value_o == 32'sd0)
    else $error("nonzero value on give-up");

  // at least two terms are always summed
  a_terms_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> terms_used_o >= N_W'(2))
    else $error("term count below two");

endmodule

bind taylor_sine_unit tsu_checker u_tsu_checker (.*);

/* test/tb_taylor_sine_unit.sv */
// tb_taylor_sine_unit: self-checking bench for the taylor series sine unit
// drives angles and register writes, predicts every result bit for bit and compares
// depends on tsu_pkg and taylor_sine_unit
module tb_taylor_sine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsu_pkg::*;

  // predictor formats
  localparam int FRAC_W     = 40;
  localparam int OUT_FRAC_W = 30;
  localparam logic [63:0] TWO_PI_FX = 64'd6908429469410;
  localparam logic [63:0] MAG_LIM   = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // handy angles in the input format
  localparam logic [31:0] ONE_RAD    = 32'd1 << ANGLE_FRAC_BITS;
  localparam logic [31:0] HALF_PI    = 32'd26353589;
  localparam logic [31:0] PI_ANGLE   = 32'd52707179;
  localparam logic [31:0] TURN_ANGLE = 32'(TWO_PI_FX >> (FRAC_W - ANGLE_FRAC_BITS));

  // run control
  localparam int RAND_PHASES    = 8;
  localparam int RAND_PER_PHASE = 166;
  localparam int IDLE_HEAVY     = 58;
  localparam int IDLE_MID       = 32;
  localparam int END_WAIT       = 2500;
  localparam int CYCLE_LIMIT    = 10_000_000;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic signed [31:0] sine;
    logic [N_W-1:0]     terms;
    logic               gave;
  } sine_res_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start_i     = 1'b0;
  logic                  busy_o;
  logic signed [31:0]    angle_i     = '0;
  logic                  done_o;
  logic signed [31:0]    sine_value_o;
  logic [N_W-1:0]        terms_used_o;
  logic                  gave_up_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [31:0]           cfg_wdata_i = '0;

  // bench state
  logic [31:0]     angle_pending[$];
  sine_res_t       sine_expected[$];
  logic [31:0]     tol_mirror   = TOL_RESET;
  logic [N_W-1:0]  limit_mirror = LIMIT_CAP;
  logic            took_cmd     = 1'b0;
  int              idle_pct     = 0;
  int              err_cnt      = 0;
  int              cycle_cnt    = 0;

  taylor_sine_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .angle_i      (angle_i),
    .done_o       (done_o),
    .sine_value_o (sine_value_o),
    .terms_used_o (terms_used_o),
    .gave_up_o    (gave_up_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // magnitude of a signed fixed-point value
  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // truncated product of two magnitudes, saturated
  function automatic logic [63:0] q40_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = ({64'd0, a} * {64'd0, b}) >> FRAC_W;
    return (prod > {64'd0, MAG_LIM}) ? MAG_LIM : prod[63:0];
  endfunction

  // expected result of one angle under the given register values
  function automatic sine_res_t predict_sine(input logic [31:0] ang, input logic [31:0] tol,
                                             input logic [N_W-1:0] lim);
    sine_res_t          res;
    logic [63:0]        mag, xsq, div, step, q;
    logic signed [63:0] term, sum;
    logic [127:0]       lhs, rhs;
    int                 n;
    bit                 stop, quit;
    // range reduction keeps the sign of the angle
    mag  = ang[31] ? (64'h1_0000_0000 - {32'd0, ang}) : {32'd0, ang};
    mag  = (mag << (FRAC_W - ANGLE_FRAC_BITS)) % TWO_PI_FX;
    term = ang[31] ? -$signed(mag) : $signed(mag);
    sum  = term;
    xsq  = q40_mul(mag, mag);
    n    = 1;
    stop = 1'b0;
    quit = 1'b0;
    // series loop: zero-sum and convergence tests first, then the term limit
    while (!stop) begin
      div  = 64'((2 * n) * (2 * n + 1));
      step = q40_mul(abs64(term), xsq) / div;
      term = (term > 0) ? -$signed(step) : $signed(step);
      sum  = sum + term;
      if (sum > SUM_MAX) sum = SUM_MAX;
      else if (sum < -SUM_MAX) sum = -SUM_MAX;
      n++;
      if (sum == 0) begin
        stop = 1'b1;
      end else begin
        lhs = {64'd0, abs64(term)} << 32;
        rhs = {96'd0, tol} * {64'd0, abs64(sum)};
        if (lhs <= rhs) begin
          stop = 1'b1;
        end else if (n > lim) begin
          stop = 1'b1;
          quit = 1'b1;
        end
      end
    end
    // output rounding toward zero with saturation
    if (quit) begin
      res.sine = '0;
    end else begin
      q = abs64(sum) >> (FRAC_W - OUT_FRAC_W);
      if (sum < 0) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        res.sine = ~q[31:0] + 32'd1;
      end else begin
        res.sine = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
    end
    res.terms = n[N_W-1:0];
    res.gave  = quit;
    return res;
  endfunction

  // one register write transaction, only issued while the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TOL:   tol_mirror = data;
      REG_LIMIT: limit_mirror = (data[N_W-1:0] > LIMIT_CAP) ? LIMIT_CAP : data[N_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_IDX_W'($urandom);
    cfg_wdata_i <= $urandom;
  endtask

  // block until every queued angle has been taken and answered
  task automatic wait_idle();
    do @(negedge clk_i); while (angle_pending.size() != 0 || sine_expected.size() != 0);
  endtask

  // command driver: holds start until the transaction is taken
  always @(negedge clk_i) begin : drive_blk
    logic        nxt_start;
    logic [31:0] nxt_angle;
    nxt_start = start_i;
    nxt_angle = angle_i;
    if (start_i && took_cmd) begin
      angle_pending.delete(0);
      nxt_start = 1'b0;
    end
    if (!nxt_start) begin
      nxt_angle = $urandom;
      if (angle_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt_start = 1'b1;
        nxt_angle = angle_pending[0];
      end
    end
    start_i <= nxt_start;
    angle_i <= nxt_angle;
  end

  // monitor: check results, then record newly accepted angles
  always @(posedge clk_i) begin : watch_blk
    sine_res_t want;
    took_cmd <= rst_ni && start_i && !busy_o;
    if (rst_ni && done_o) begin
      if (sine_expected.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result act %h/%0d/%0b (sine_value/terms_used/gave_up)",
                   $time, sine_value_o, terms_used_o, gave_up_o);
      end else begin
        want = sine_expected.pop_front();
        if (sine_value_o !== want.sine || terms_used_o !== want.terms ||
            gave_up_o !== want.gave) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: exp %h/%0d/%0b act %h/%0d/%0b (sine_value/terms_used/gave_up)",
                     $time, want.sine, want.terms, want.gave,
                     sine_value_o, terms_used_o, gave_up_o);
        end
      end
    end
    if (rst_ni && start_i && !busy_o)
      sine_expected.push_back(predict_sine(angle_i, tol_mirror, limit_mirror));
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // stimulus sequence
  initial begin : stim_blk
    int          p, k;
    logic [31:0] a, tol_val, lim_val;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // default registers: zero, extremes, quadrant points, values around one turn
    idle_pct = 0;
    angle_pending.push_back(32'd0);
    angle_pending.push_back(32'd1);
    angle_pending.push_back(32'hFFFF_FFFF);
    angle_pending.push_back(32'h7FFF_FFFF);
    angle_pending.push_back(32'h8000_0000);
    angle_pending.push_back(ONE_RAD);
    angle_pending.push_back(-ONE_RAD);
    angle_pending.push_back(HALF_PI);
    angle_pending.push_back(-PI_ANGLE);
    angle_pending.push_back(TURN_ANGLE);
    angle_pending.push_back(TURN_ANGLE + 32'd1);
    angle_pending.push_back(-(TURN_ANGLE + 32'd1));
    wait_idle();

    // zero tolerance runs the series until the term vanishes; limit above the cap
    write_reg(REG_TOL, 32'd0);
    write_reg(REG_LIMIT, 32'd1023);
    angle_pending.push_back(32'h7FFF_FFFF);
    angle_pending.push_back(32'h8000_0000);
    angle_pending.push_back(TURN_ANGLE);
    wait_idle();

    // tolerance near one stops the series early on large angles
    write_reg(REG_TOL, 32'hFFFF_FFFF);
    write_reg(REG_LIMIT, 32'd1000);
    angle_pending.push_back(ONE_RAD * 6);
    angle_pending.push_back(-(ONE_RAD * 6));
    angle_pending.push_back(ONE_RAD * 4);
    angle_pending.push_back(-(ONE_RAD * 4));
    wait_idle();

    // zero limit: give up unless the first term converges or the sum is zero
    write_reg(REG_TOL, TOL_RESET);
    write_reg(REG_LIMIT, 32'd0);
    angle_pending.push_back(ONE_RAD);
    angle_pending.push_back(32'd0);
    angle_pending.push_back(32'd1);
    wait_idle();

    // limit bits above the field are dropped, unknown indexes are ignored
    write_reg(REG_LIMIT, 32'hFFFF_FC05);
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'd0);
    angle_pending.push_back(32'h7FFF_FFFF);
    angle_pending.push_back(HALF_PI);
    wait_idle();

    // random phases, each with its own limit, mostly a new tolerance, and its own sender idling
    for (p = 0; p < RAND_PHASES; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? IDLE_HEAVY : IDLE_MID);
      case ($urandom_range(0, 4))
        0:       tol_val = 32'd0;
        1:       tol_val = 32'hFFFF_FFFF;
        2:       tol_val = TOL_RESET;
        3:       tol_val = $urandom >> $urandom_range(0, 31);
        default: tol_val = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       lim_val = $urandom_range(0, 2);
        1:       lim_val = $urandom_range(3, 30);
        2:       lim_val = $urandom;
        3:       lim_val = $urandom_range(1001, 1023);
        default: lim_val = 32'd1000;
      endcase
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_TOL, tol_val);
      write_reg(REG_LIMIT, lim_val);
      if ($urandom_range(0, 3) == 0) write_reg(p[0] ? REG_SPARE_A : REG_SPARE_B, $urandom);
      for (k = 0; k < RAND_PER_PHASE; k++) begin
        case ($urandom_range(0, 9))
          0, 1: a = $urandom;
          2: begin
            case ($urandom_range(0, 4))
              0:       a = 32'h7FFF_FFFF;
              1:       a = 32'h8000_0000;
              2:       a = 32'd0;
              3:       a = 32'd1;
              default: a = 32'hFFFF_FFFF;
            endcase
          end
          3:       a = $urandom_range(0, 4095);
          4:       a = TURN_ANGLE * $urandom_range(1, 20) + $urandom_range(0, 6) - 32'd3;
          default: a = $urandom_range(0, ONE_RAD * 8);
        endcase
        if ($urandom_range(0, 1)) a = ~a + 32'd1;
        angle_pending.push_back(a);
        // sender holds off here until every outstanding result is back
        if (k == RAND_PER_PHASE / 2) wait_idle();
      end
      wait_idle();
    end

    // drain, then watch for stray results
    repeat (END_WAIT) @(posedge clk_i);
    if (sine_expected.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, sine_expected.size());
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
